/* rtl/dsf_pkg.sv */
// dsf_pkg: shared types, constants and fixed-point helpers for the damped spring follower
// used by dsf_regs, dsf_ctrl, dsf_dp and damped_spring_follow_top
package dsf_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 31;
    localparam int PROD_W = 2 * WORD_W;
    localparam int QUOT_W = WORD_W + FRAC_W;
    localparam int SQRT_STEPS = PROD_W / 2;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t VMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t VMIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [2:0] REG_REST      = 3'd0;
    localparam logic [2:0] REG_STIFFNESS = 3'd1;
    localparam logic [2:0] REG_DAMPING   = 3'd2;
    localparam logic [2:0] REG_INV_MASS  = 3'd3;
    localparam logic [2:0] REG_TIME_STEP = 3'd4;
    localparam logic [2:0] REG_START_X   = 3'd5;
    localparam logic [2:0] REG_START_Y   = 3'd6;
    localparam logic [2:0] REG_START_Z   = 3'd7;

    localparam logic [2:0] FS_KU = 3'd0;
    localparam logic [2:0] FS_DV = 3'd1;
    localparam logic [2:0] FS_AM = 3'd2;
    localparam logic [2:0] FS_VT = 3'd3;
    localparam logic [2:0] FS_PT = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_ISSUE,
        OP_SQ_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_KS_ISSUE,
        OP_KS_WB,
        OP_F_ISSUE,
        OP_F_WB,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [2:0] fstep;
    } cmd_t;

    typedef struct packed {
        logic sqrt_last;
        logic div_last;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] rest_length;
        logic [CFG_W-1:0] stiffness;
        logic [CFG_W-1:0] damping;
        logic [CFG_W-1:0] inverse_mass;
        logic [CFG_W-1:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic       wr;
        logic [1:0] axis;
        word_t      value;
    } start_wr_t;

    function automatic word_t sat33(input logic signed [WORD_W:0] v);
        if (v[WORD_W] != v[WORD_W-1])
        begin
            return v[WORD_W] ? VMIN : VMAX;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] mag(input word_t v);
        return v[WORD_W-1] ? WORD_W'(-v) : v;
    endfunction

    function automatic word_t fneg(input word_t v);
        return (v == VMIN) ? VMAX : -v;
    endfunction

    // product magnitude and sign to a saturated fixed-point word
    function automatic word_t fmul_fin(input logic [PROD_W-1:0] prod, input logic neg);
        logic [PROD_W-FRAC_W-1:0] sh;
        sh = prod[PROD_W-1:FRAC_W];
        if (neg)
        begin
            if (sh > {{(PROD_W-FRAC_W-WORD_W){1'b0}}, VMIN})
            begin
                return VMIN;
            end
            return word_t'(-sh[WORD_W-1:0]);
        end
        if (sh > (PROD_W-FRAC_W)'(VMAX))
        begin
            return VMAX;
        end
        return sh[WORD_W-1:0];
    endfunction

endpackage

/* rtl/damped_spring_follow_top.sv */
// damped_spring_follow_top: top level of the damped spring follower
// depends on dsf_pkg, dsf_regs, dsf_ctrl, dsf_dp
//
// Each target point taken on the input stream advances a 3D spring-damper body by one
// semi-implicit Euler step in saturating signed Q16.16 and returns the new position and
// velocity. The steps run in order: the squared length on the shared 32x32 multiplier,
// the bit-serial square root, three bit-serial 48-bit divisions forming the unit vector,
// the force and integration multiplies, and the load of the output register. The next
// item is taken once the previous one is finished, and a finished result waits in an
// output register while the next runs. Writing a start register sets that position
// coordinate and clears the velocity.
module damped_spring_follow_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // target_x, target_y, target_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    dsf_pkg::cfg_t      cfg;
    dsf_pkg::start_wr_t start_wr;
    dsf_pkg::cmd_t      cmd;
    dsf_pkg::stat_t     stat;

    assign pready = 1'b1;

    dsf_regs u_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .start_wr (start_wr)
    );

    dsf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsf_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .start_wr  (start_wr),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .stat      (stat)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == dsf_pkg::OP_OUT |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result register overwritten before transfer");

    a_out_drops: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && cmd.op != dsf_pkg::OP_OUT |=> !m_axis_tvalid)
        else $error("result repeated after transfer");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result changed");

endmodule

/* rtl/dsf_regs.sv */
// dsf_regs: configuration register file behind the apb-style port
// depends on dsf_pkg
module dsf_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output dsf_pkg::cfg_t       cfg,
    output dsf_pkg::start_wr_t  start_wr
);

    logic [dsf_pkg::CFG_W-1:0] rest_reg, stiff_reg, damp_reg, invm_reg, dt_reg;
    dsf_pkg::word_t            sx_reg, sy_reg, sz_reg;
    logic                      wr;
    logic [2:0]                idx;

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg  <= '0;
            stiff_reg <= 31'd65536;
            damp_reg  <= '0;
            invm_reg  <= 31'd65536;
            dt_reg    <= 31'd1092;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sz_reg    <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                dsf_pkg::REG_REST:      rest_reg  <= pwdata[30:0];
                dsf_pkg::REG_STIFFNESS: stiff_reg <= pwdata[30:0];
                dsf_pkg::REG_DAMPING:   damp_reg  <= pwdata[30:0];
                dsf_pkg::REG_INV_MASS:  invm_reg  <= pwdata[30:0];
                dsf_pkg::REG_TIME_STEP: dt_reg    <= pwdata[30:0];
                dsf_pkg::REG_START_X:   sx_reg    <= pwdata;
                dsf_pkg::REG_START_Y:   sy_reg    <= pwdata;
                dsf_pkg::REG_START_Z:   sz_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            dsf_pkg::REG_REST:      prdata = {1'b0, rest_reg};
            dsf_pkg::REG_STIFFNESS: prdata = {1'b0, stiff_reg};
            dsf_pkg::REG_DAMPING:   prdata = {1'b0, damp_reg};
            dsf_pkg::REG_INV_MASS:  prdata = {1'b0, invm_reg};
            dsf_pkg::REG_TIME_STEP: prdata = {1'b0, dt_reg};
            dsf_pkg::REG_START_X:   prdata = sx_reg;
            dsf_pkg::REG_START_Y:   prdata = sy_reg;
            dsf_pkg::REG_START_Z:   prdata = sz_reg;
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        start_wr.value = pwdata;
        start_wr.wr    = 1'b0;
        start_wr.axis  = dsf_pkg::AXIS_X;
        unique case (idx)
            dsf_pkg::REG_START_X:
            begin
                start_wr.wr   = wr;
                start_wr.axis = dsf_pkg::AXIS_X;
            end
            dsf_pkg::REG_START_Y:
            begin
                start_wr.wr   = wr;
                start_wr.axis = dsf_pkg::AXIS_Y;
            end
            dsf_pkg::REG_START_Z:
            begin
                start_wr.wr   = wr;
                start_wr.axis = dsf_pkg::AXIS_Z;
            end
            default: ;
        endcase
    end

    assign cfg.rest_length  = rest_reg;
    assign cfg.stiffness    = stiff_reg;
    assign cfg.damping      = damp_reg;
    assign cfg.inverse_mass = invm_reg;
    assign cfg.time_step    = dt_reg;

endmodule

/* rtl/dsf_ctrl.sv */
// dsf_ctrl: sequencer state machine issuing datapath commands per item
// depends on dsf_pkg
module dsf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dsf_pkg::stat_t  stat,
    output dsf_pkg::cmd_t   cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_SQ        = 12'b000000000010,
        S_SQACC     = 12'b000000000100,
        S_SQRT_INIT = 12'b000000001000,
        S_SQRT      = 12'b000000010000,
        S_DIV_INIT  = 12'b000000100000,
        S_DIV       = 12'b000001000000,
        S_KS        = 12'b000010000000,
        S_KSW       = 12'b000100000000,
        S_FMUL      = 12'b001000000000,
        S_FWB       = 12'b010000000000,
        S_DONE      = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [2:0] fstep_reg, fstep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= dsf_pkg::AXIS_X;
            fstep_reg <= dsf_pkg::FS_KU;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            fstep_reg <= fstep_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cmd.axis  = axis_reg;
    assign cmd.fstep = fstep_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        fstep_next = fstep_reg;
        cmd.op     = dsf_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = dsf_pkg::OP_LOAD;
                    axis_next  = dsf_pkg::AXIS_X;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op     = dsf_pkg::OP_SQ_ISSUE;
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                cmd.op = dsf_pkg::OP_SQ_ACC;
                if (axis_reg == dsf_pkg::AXIS_Z)
                begin
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = dsf_pkg::OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = dsf_pkg::OP_SQRT_STEP;
                if (stat.sqrt_last)
                begin
                    axis_next  = dsf_pkg::AXIS_X;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = dsf_pkg::OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = dsf_pkg::OP_DIV_STEP;
                if (stat.div_last)
                begin
                    if (axis_reg == dsf_pkg::AXIS_Z)
                    begin
                        state_next = S_KS;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIV_INIT;
                    end
                end
            end
            S_KS:
            begin
                cmd.op     = dsf_pkg::OP_KS_ISSUE;
                state_next = S_KSW;
            end
            S_KSW:
            begin
                cmd.op     = dsf_pkg::OP_KS_WB;
                axis_next  = dsf_pkg::AXIS_X;
                fstep_next = dsf_pkg::FS_KU;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.op     = dsf_pkg::OP_F_ISSUE;
                state_next = S_FWB;
            end
            S_FWB:
            begin
                cmd.op     = dsf_pkg::OP_F_WB;
                state_next = S_FMUL;
                if (fstep_reg == dsf_pkg::FS_PT)
                begin
                    fstep_next = dsf_pkg::FS_KU;
                    if (axis_reg == dsf_pkg::AXIS_Z)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    fstep_next = fstep_reg + 3'd1;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = dsf_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dsf_dp.sv */
// dsf_dp: datapath with state vectors, shared multiplier, bit-serial sqrt and divider
// depends on dsf_pkg
module dsf_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  dsf_pkg::cmd_t       cmd,
    input  dsf_pkg::cfg_t       cfg,
    input  dsf_pkg::start_wr_t  start_wr,
    input  logic [95:0]         in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [191:0]        out_data,
    output dsf_pkg::stat_t      stat
);

    localparam int W  = dsf_pkg::WORD_W;
    localparam int PW = dsf_pkg::PROD_W;
    localparam int QW = dsf_pkg::QUOT_W;

    dsf_pkg::word_t pos_reg [3];
    dsf_pkg::word_t vel_reg [3];
    dsf_pkg::word_t d_reg   [3];
    dsf_pkg::word_t u_reg   [3];
    dsf_pkg::word_t tgt     [3];

    logic [PW-1:0]   sum_reg, prod_reg, rad_reg;
    logic            neg_reg;
    logic [W+3:0]    rem_reg;
    logic [W-1:0]    root_reg;
    logic [4:0]      sq_cnt_reg;
    logic [QW-1:0]   num_reg, q_reg;
    logic [W-1:0]    drem_reg;
    logic [5:0]      dv_cnt_reg;
    logic [W-2:0]    len_reg;
    dsf_pkg::word_t  ks_reg, t1_reg, f_reg, a_reg;
    logic [191:0]    out_reg;
    logic            out_valid_reg;

    dsf_pkg::word_t  opa, opb, stretch, m, nm, sel_d;
    logic [W+3:0]    rem_sh, trial;
    logic            sq_ge;
    logic [W-1:0]    root_new;
    logic [W:0]      r2;
    logic            dv_ge;
    logic [QW-1:0]   q_new;
    dsf_pkg::word_t  qs, u_new;

    assign tgt[0] = in_data[31:0];
    assign tgt[1] = in_data[63:32];
    assign tgt[2] = in_data[95:64];
    assign sel_d  = d_reg[cmd.axis];

    assign stretch = dsf_pkg::sat33($signed({2'b00, len_reg}) - $signed({2'b00, cfg.rest_length}));
    assign m       = dsf_pkg::fmul_fin(prod_reg, neg_reg);
    assign nm      = dsf_pkg::fneg(m);

    always_comb
    begin
        opa = sel_d;
        opb = sel_d;
        case (cmd.op)
            dsf_pkg::OP_KS_ISSUE:
            begin
                opa = {1'b0, cfg.stiffness};
                opb = stretch;
            end
            dsf_pkg::OP_F_ISSUE:
            begin
                case (cmd.fstep)
                    dsf_pkg::FS_KU:
                    begin
                        opa = ks_reg;
                        opb = u_reg[cmd.axis];
                    end
                    dsf_pkg::FS_DV:
                    begin
                        opa = {1'b0, cfg.damping};
                        opb = vel_reg[cmd.axis];
                    end
                    dsf_pkg::FS_AM:
                    begin
                        opa = f_reg;
                        opb = {1'b0, cfg.inverse_mass};
                    end
                    dsf_pkg::FS_VT:
                    begin
                        opa = a_reg;
                        opb = {1'b0, cfg.time_step};
                    end
                    default:
                    begin
                        opa = vel_reg[cmd.axis];
                        opb = {1'b0, cfg.time_step};
                    end
                endcase
            end
            default: ;
        endcase
    end

    // square root digit step
    assign rem_sh   = {rem_reg[W+1:0], rad_reg[PW-1:PW-2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (rem_sh >= trial);
    assign root_new = {root_reg[W-2:0], sq_ge};

    // divider bit step
    assign r2    = {drem_reg, num_reg[QW-1]};
    assign dv_ge = (r2 >= {2'b00, len_reg});
    assign q_new = {q_reg[QW-2:0], dv_ge};
    assign qs    = (|q_new[QW-1:W-1]) ? dsf_pkg::VMAX : q_new[W-1:0];
    assign u_new = (len_reg == '0) ? '0 : (sel_d[W-1] ? -qs : qs);

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(dsf_pkg::mag(opa)) * PW'(dsf_pkg::mag(opb));
        neg_reg  <= opa[W-1] ^ opb[W-1];
        case (cmd.op)
            dsf_pkg::OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i] <= dsf_pkg::sat33({pos_reg[i][W-1], pos_reg[i]}
                                               - {tgt[i][W-1], tgt[i]});
                end
                sum_reg <= '0;
            end
            dsf_pkg::OP_SQ_ACC:
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            dsf_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= sum_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            dsf_pkg::OP_SQRT_STEP:
            begin
                rad_reg  <= {rad_reg[PW-3:0], 2'b00};
                rem_reg  <= sq_ge ? (rem_sh - trial) : rem_sh;
                root_reg <= root_new;
                if (stat.sqrt_last)
                begin
                    len_reg <= root_new[W-1] ? dsf_pkg::VMAX[W-2:0] : root_new[W-2:0];
                end
            end
            dsf_pkg::OP_DIV_INIT:
            begin
                num_reg  <= {dsf_pkg::mag(sel_d), {dsf_pkg::FRAC_W{1'b0}}};
                drem_reg <= '0;
                q_reg    <= '0;
            end
            dsf_pkg::OP_DIV_STEP:
            begin
                num_reg  <= {num_reg[QW-2:0], 1'b0};
                drem_reg <= dv_ge ? W'(r2 - {2'b00, len_reg}) : r2[W-1:0];
                q_reg    <= q_new;
                if (stat.div_last)
                begin
                    u_reg[cmd.axis] <= u_new;
                end
            end
            dsf_pkg::OP_KS_WB:
            begin
                ks_reg <= m;
            end
            dsf_pkg::OP_F_WB:
            begin
                case (cmd.fstep)
                    dsf_pkg::FS_KU: t1_reg <= nm;
                    dsf_pkg::FS_DV:
                    begin
                        f_reg <= dsf_pkg::sat33({t1_reg[W-1], t1_reg} + {nm[W-1], nm});
                    end
                    dsf_pkg::FS_AM: a_reg <= m;
                    default: ;
                endcase
            end
            dsf_pkg::OP_OUT:
            begin
                out_reg <= {vel_reg[2], vel_reg[1], vel_reg[0],
                            pos_reg[2], pos_reg[1], pos_reg[0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            sq_cnt_reg    <= '0;
            dv_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start_wr.wr)
            begin
                pos_reg[start_wr.axis] <= start_wr.value;
                for (int i = 0; i < 3; i++)
                begin
                    vel_reg[i] <= '0;
                end
            end
            else if (cmd.op == dsf_pkg::OP_F_WB && cmd.fstep == dsf_pkg::FS_VT)
            begin
                vel_reg[cmd.axis] <= dsf_pkg::sat33({vel_reg[cmd.axis][W-1], vel_reg[cmd.axis]}
                                                    + {m[W-1], m});
            end
            else if (cmd.op == dsf_pkg::OP_F_WB && cmd.fstep == dsf_pkg::FS_PT)
            begin
                pos_reg[cmd.axis] <= dsf_pkg::sat33({pos_reg[cmd.axis][W-1], pos_reg[cmd.axis]}
                                                    + {m[W-1], m});
            end

            if (cmd.op == dsf_pkg::OP_SQRT_INIT)
            begin
                sq_cnt_reg <= '0;
            end
            else if (cmd.op == dsf_pkg::OP_SQRT_STEP)
            begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
            end

            if (cmd.op == dsf_pkg::OP_DIV_INIT)
            begin
                dv_cnt_reg <= '0;
            end
            else if (cmd.op == dsf_pkg::OP_DIV_STEP)
            begin
                dv_cnt_reg <= dv_cnt_reg + 6'd1;
            end

            if (cmd.op == dsf_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.sqrt_last = (sq_cnt_reg == 5'(dsf_pkg::SQRT_STEPS - 1));
    assign stat.div_last  = (dv_cnt_reg == 6'(QW - 1));
    assign stat.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* tb/tb_damped_spring_follow_top.sv */
// testbench for damped_spring_follow_top: drives target points and apb register writes,
// predicts each position/velocity result in a scoreboard class and checks it in order
// depends on dsf_pkg and the damped_spring_follow_top rtl
module tb_damped_spring_follow_top;

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int IDLE_LIMIT = 20000;

    class spring_scoreboard;
        longint rest_len, stiff, damp, inv_mass, dt;
        longint pos[3];
        longint vel[3];
        logic [191:0] pending_q[$];
        int errors;

        function new();
            rest_len = 0;
            stiff = 65536;
            damp = 0;
            inv_mass = 65536;
            dt = 1092;
            for (int i = 0; i < 3; i++)
            begin
                pos[i] = 0;
                vel[i] = 0;
            end
            errors = 0;
        endfunction

        function longint clamp(longint v);
            if (v > MAXV)
            begin
                return MAXV;
            end
            if (v < MINV)
            begin
                return MINV;
            end
            return v;
        endfunction

        function logic [63:0] magnitude(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        // q16.16 multiply, truncate toward zero, saturate
        function longint qmul(longint a, longint b);
            logic [127:0] p;
            logic [127:0] ma;
            logic [127:0] mb;
            bit neg;
            neg = (a < 0) != (b < 0);
            ma = {64'b0, magnitude(a)};
            mb = {64'b0, magnitude(b)};
            p = (ma * mb) >> 16;
            if (neg)
            begin
                if (p >= 128'h80000000)
                begin
                    return MINV;
                end
                return -longint'(p[63:0]);
            end
            if (p > 128'h7fffffff)
            begin
                return MAXV;
            end
            return longint'(p[63:0]);
        endfunction

        function logic [63:0] root_floor(logic [127:0] n);
            logic [127:0] r;
            logic [127:0] c;
            r = 0;
            for (int b = 48; b >= 0; b--)
            begin
                c = r | (128'd1 << b);
                if (c * c <= n)
                begin
                    r = c;
                end
            end
            return r[63:0];
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            longint u;
            longint s;
            u = longint'(v & 32'h7fffffff);
            s = longint'($signed(v));
            case (idx)
                dsf_pkg::REG_REST:      rest_len = u;
                dsf_pkg::REG_STIFFNESS: stiff = u;
                dsf_pkg::REG_DAMPING:   damp = u;
                dsf_pkg::REG_INV_MASS:  inv_mass = u;
                dsf_pkg::REG_TIME_STEP: dt = u;
                default:
                begin
                    pos[idx - dsf_pkg::REG_START_X] = s;
                    for (int i = 0; i < 3; i++)
                    begin
                        vel[i] = 0;
                    end
                end
            endcase
        endfunction

        function void note_target(logic [95:0] tgt);
            longint d[3];
            longint u[3];
            longint len, stretch, ks, f, acc;
            logic [127:0] sum;
            logic [127:0] m;
            logic [127:0] q;
            logic [63:0] r;
            logic [191:0] res;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = clamp(pos[i] - longint'($signed(tgt[32*i +: 32])));
                m = {64'b0, magnitude(d[i])};
                sum = sum + m * m;
            end
            r = root_floor(sum);
            len = (r > 64'h7fffffff) ? MAXV : longint'(r);
            for (int i = 0; i < 3; i++)
            begin
                if (len == 0)
                begin
                    u[i] = 0;
                end
                else
                begin
                    q = ({64'b0, magnitude(d[i])} << 16) / len;
                    u[i] = (q > 128'h7fffffff) ? MAXV : longint'(q[63:0]);
                    if (d[i] < 0)
                    begin
                        u[i] = -u[i];
                    end
                end
            end
            stretch = clamp(len - rest_len);
            ks = qmul(stiff, stretch);
            for (int i = 0; i < 3; i++)
            begin
                f = clamp(clamp(-qmul(ks, u[i])) + clamp(-qmul(damp, vel[i])));
                acc = qmul(f, inv_mass);
                vel[i] = clamp(vel[i] + qmul(acc, dt));
                pos[i] = clamp(pos[i] + qmul(vel[i], dt));
            end
            for (int i = 0; i < 3; i++)
            begin
                res[32*i +: 32] = pos[i][31:0];
                res[96 + 32*i +: 32] = vel[i][31:0];
            end
            pending_q.push_back(res);
        endfunction

        function void check_state(logic [191:0] got);
            logic [191:0] want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            for (int i = 0; i < 6; i++)
            begin
                if (want[32*i +: 32] !== got[32*i +: 32])
                begin
                    $display("%0t: field %0d expected %h actual %h", $time, i,
                             want[32*i +: 32], got[32*i +: 32]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    spring_scoreboard sb;
    bit no_idle;
    int idle_cycles;

    damped_spring_follow_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic apb_write(int idx, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic wait_drained();
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic send_target(logic [95:0] tgt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tgt;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_target(tgt);
    endtask

    function automatic logic [31:0] rand_coord(int mode, longint near);
        case (mode)
            0: return $urandom;
            1: return 32'(near + $signed($urandom_range(0, 32'h1fffff)) - 32'h100000);
            2: return 32'(near);
            default: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'h200000);
        endcase
    endfunction

    task automatic random_targets(int count);
        logic [95:0] tgt;
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            mode = (mode < 2) ? 0 : (mode < 3) ? 2 : (mode < 7) ? 1 : 3;
            for (int i = 0; i < 3; i++)
            begin
                tgt[32*i +: 32] = rand_coord(mode, sb.pos[i]);
            end
            if ($urandom_range(0, 49) == 0)
            begin
                no_idle = ~no_idle;
            end
            send_target(tgt);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic random_config();
        logic [31:0] v;
        for (int idx = dsf_pkg::REG_REST; idx <= dsf_pkg::REG_START_Z; idx++)
        begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom_range(0, 32'h40000);
                2: v = (idx <= dsf_pkg::REG_TIME_STEP) ? $urandom_range(0, 4096)
                                                       : $urandom_range(0, 32'hfffff);
                default: v = (idx == dsf_pkg::REG_TIME_STEP) ? 32'd1092
                                                             : $urandom_range(0, 32'h30000);
            endcase
            apb_write(idx, v);
        end
    endtask

    initial
    begin
        logic [95:0] dir_q[$];
        logic [31:0] ext[4];
        clk = 1'b0;
        idle_cycles = 0;
        no_idle = 1'b0;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: zero length, extremes of every coordinate
        ext = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
        dir_q.push_back('0);
        dir_q.push_back({32'h0, 32'h0, 32'h00010000});
        for (int i = 0; i < 4; i++)
        begin
            dir_q.push_back({ext[i], ext[i], ext[i]});
            dir_q.push_back({ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]});
        end
        foreach (dir_q[k])
        begin
            send_target(dir_q[k]);
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // extremes of all registers, then start on the edge of range
        for (int idx = dsf_pkg::REG_REST; idx <= dsf_pkg::REG_TIME_STEP; idx++)
        begin
            apb_write(idx, 32'hffffffff);
        end
        apb_write(dsf_pkg::REG_START_X, 32'h7fffffff);
        apb_write(dsf_pkg::REG_START_Y, 32'h80000000);
        apb_write(dsf_pkg::REG_START_Z, 32'h00000000);
        send_target({32'h7fffffff, 32'h7fffffff, 32'h80000000});
        send_target({32'h0, 32'h0, 32'h0});
        send_target({32'h80000000, 32'h80000000, 32'h7fffffff});
        s_axis_tvalid <= 1'b0;
        wait_drained();
        for (int idx = dsf_pkg::REG_REST; idx <= dsf_pkg::REG_START_Z; idx++)
        begin
            apb_write(idx, 32'h0);
        end
        send_target({32'h0, 32'h0, 32'h0});
        send_target({32'h00030000, 32'hfffd0000, 32'h00010000});
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // damped spring with a nonzero rest length
        apb_write(dsf_pkg::REG_REST, 32'h00010000);
        apb_write(dsf_pkg::REG_STIFFNESS, 32'h00040000);
        apb_write(dsf_pkg::REG_DAMPING, 32'h00008000);
        apb_write(dsf_pkg::REG_INV_MASS, 32'h00010000);
        apb_write(dsf_pkg::REG_TIME_STEP, 32'h00001000);
        random_targets(110);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            random_config();
            random_targets(110);
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_axis_tvalid);
            sb.check_state(m_axis_tdata);
        end
    end

endmodule
